@@ rtl/core/canny_hysteresis_3x3_assert.svh @@
// ----------------------------------------------------------------------------
// canny_hysteresis_3x3 assertion macros
// concurrent assertion wrappers, empty in synthesis builds
// ----------------------------------------------------------------------------
`ifndef CANNY_HYSTERESIS_3X3_ASSERT_SVH
`define CANNY_HYSTERESIS_3X3_ASSERT_SVH

`ifndef SYNTHESIS

// clocked on clk_i, off while rst_ni is low
`define CHYS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked on clk_i, also checked during reset
`define CHYS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define CHYS_ASSERT(lbl, prop, msg)

`define CHYS_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/core/chys_pkg.sv @@
// ----------------------------------------------------------------------------
// chys_pkg
// shared constants and types of the 3x3 hysteresis threshold block
// ----------------------------------------------------------------------------
`default_nettype none

package chys_pkg;

  localparam int unsigned LINE_DEPTH_DEF = 2048;
  localparam int unsigned PIXEL_BITS_DEF = 16;

  localparam int unsigned MAX_ROWS = 4096;

  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam int unsigned CFG_INDEX_BITS = 2;

  localparam logic [7:0] EDGE_ON  = 8'd255;
  localparam logic [7:0] EDGE_OFF = 8'd0;

  localparam logic [12:0] ROW_COUNT_RST = 13'd480;
  localparam logic [11:0] COL_COUNT_RST = 12'd640;
  localparam logic [15:0] HIGH_THR_RST  = 16'd100;
  localparam logic [15:0] LOW_THR_RST   = 16'd50;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ROW_COUNT = 2'd0,
    REG_COL_COUNT = 2'd1,
    REG_HIGH_THR  = 2'd2,
    REG_LOW_THR   = 2'd3
  } cfg_reg_e;

endpackage

`default_nettype wire

@@ rtl/core/chys_line_ram.sv @@
// ----------------------------------------------------------------------------
// chys_line_ram
// simple dual-port line buffer memory, one write and one registered read
// ----------------------------------------------------------------------------
`default_nettype none

module chys_line_ram #(
  parameter int unsigned DEPTH     = chys_pkg::LINE_DEPTH_DEF,
  parameter int unsigned WIDTH     = 2 * chys_pkg::PIXEL_BITS_DEF,
  parameter int unsigned ADDR_BITS = $clog2(DEPTH)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rd_en_i,
  input  wire logic [ADDR_BITS-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]     rd_data_o,
  input  wire logic                 wr_en_i,
  input  wire logic [ADDR_BITS-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]     wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read returns the old word on a same-cycle write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/canny_hysteresis_3x3.sv @@
// ----------------------------------------------------------------------------
// canny_hysteresis_3x3
// hysteresis thresholding of gradient magnitudes over a 3x3 window
// ----------------------------------------------------------------------------
// Takes one magnitude word per clock and returns one edge word per clock
// while the output side does not stall. An accepted word reads the shared
// line RAM (upper and middle rows packed into one entry) at its column; when
// stage 1 advances, the window decision is made, the entry is written back
// and the result lands in the output register, from which it is offered; a
// stall on the output side holds the word in stage 1.
// The read-modify-write of the line RAM with one-entry forwarding sets the
// rate of one word per clock when the output does not stall. After reset the
// RAM holds no defined data: a fill mark over the columns written so far
// makes unwritten entries read as zero, so there is no clearing pass and
// words are taken as soon as reset is released.
`default_nettype none

`include "canny_hysteresis_3x3_assert.svh"

module canny_hysteresis_3x3 #(
  parameter int unsigned LINE_DEPTH = chys_pkg::LINE_DEPTH_DEF,
  parameter int unsigned PIXEL_BITS = chys_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [chys_pkg::CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  wire logic [chys_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [15:0]                          magnitude_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic      [7:0]                           edge_value_o,
  output logic                                      frame_start_o,
  output logic                                      frame_last_o
);

  localparam int unsigned CW = $clog2(LINE_DEPTH);
  localparam int unsigned FW = $clog2(LINE_DEPTH + 1);
  localparam int unsigned PB = PIXEL_BITS;

  // configuration
  logic [12:0] row_count_q;
  logic [11:0] col_count_q;
  logic [15:0] high_thr_q;
  logic [15:0] low_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= chys_pkg::ROW_COUNT_RST;
      col_count_q <= chys_pkg::COL_COUNT_RST;
      high_thr_q  <= chys_pkg::HIGH_THR_RST;
      low_thr_q   <= chys_pkg::LOW_THR_RST;
    end else if (cfg_we_i) begin
      unique case (chys_pkg::cfg_reg_e'(cfg_index_i))
        chys_pkg::REG_ROW_COUNT: row_count_q <= cfg_data_i[12:0];
        chys_pkg::REG_COL_COUNT: col_count_q <= cfg_data_i[11:0];
        chys_pkg::REG_HIGH_THR:  high_thr_q  <= cfg_data_i;
        chys_pkg::REG_LOW_THR:   low_thr_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamped last indices
  logic [31:0]   rc_ext;
  logic [31:0]   cc_ext;
  logic [11:0]   row_last_idx;
  logic [CW-1:0] col_last_idx;

  always_comb begin
    rc_ext = 32'(row_count_q);
    cc_ext = 32'(col_count_q);
    if (rc_ext == 32'd0) begin
      row_last_idx = '0;
    end else if (rc_ext > chys_pkg::MAX_ROWS) begin
      row_last_idx = 12'(chys_pkg::MAX_ROWS - 1);
    end else begin
      row_last_idx = 12'(rc_ext - 32'd1);
    end
    if (cc_ext == 32'd0) begin
      col_last_idx = '0;
    end else if (cc_ext > LINE_DEPTH) begin
      col_last_idx = CW'(LINE_DEPTH - 1);
    end else begin
      col_last_idx = CW'(cc_ext - 32'd1);
    end
  end

  // handshake and stage control
  logic          s1_valid_q;
  logic          out_valid_q;
  logic          s1_adv;
  logic          in_acc;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // frame position
  logic [11:0]   row_index_q;
  logic [CW-1:0] col_index_q;
  logic          row_at_last;
  logic          col_at_last;

  assign row_at_last = row_index_q >= row_last_idx;
  assign col_at_last = col_index_q >= col_last_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_index_q <= '0;
      col_index_q <= '0;
    end else if (in_acc) begin
      if (col_at_last) begin
        col_index_q <= '0;
        row_index_q <= row_at_last ? '0 : row_index_q + 12'd1;
      end else begin
        col_index_q <= col_index_q + CW'(1);
      end
    end
  end

  // stage 1 word, aligned with the line RAM read data
  logic [PB-1:0] pix1_q;
  logic [CW-1:0] addr1_q;
  logic          first1_q;
  logic          last1_q;
  logic          rd_ok_q;
  logic          fwd_q;
  logic [PB-1:0] fwd_top_q;
  logic [PB-1:0] fwd_mid_q;
  logic [FW-1:0] fill_q;

  logic [2*PB-1:0] rd_data;
  logic [PB-1:0]   top_eff;
  logic [PB-1:0]   mid_eff;
  logic            s1_write;
  logic            fwd_hit;

  assign s1_write = s1_valid_q && s1_adv;
  assign fwd_hit  = s1_write && (addr1_q == col_index_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix1_q    <= PB'(magnitude_i);
      addr1_q   <= col_index_q;
      first1_q  <= (row_index_q == '0) && (col_index_q == '0);
      last1_q   <= row_at_last && col_at_last;
      rd_ok_q   <= 32'(col_index_q) < 32'(fill_q);
      fwd_q     <= fwd_hit;
      fwd_top_q <= mid_eff;
      fwd_mid_q <= pix1_q;
    end
  end

  // columns below the fill mark have been written since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (s1_write && (32'(addr1_q) >= 32'(fill_q))) begin
      fill_q <= FW'(32'(addr1_q) + 32'd1);
    end
  end

  chys_line_ram #(
    .DEPTH     (LINE_DEPTH),
    .WIDTH     (2 * PB),
    .ADDR_BITS (CW)
  ) u_line_ram (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (col_index_q),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_write),
    .wr_addr_i (addr1_q),
    .wr_data_i ({mid_eff, pix1_q})
  );

  // entry layout: upper row in the high half, middle row in the low half
  always_comb begin
    if (fwd_q) begin
      top_eff = fwd_top_q;
      mid_eff = fwd_mid_q;
    end else if (rd_ok_q) begin
      top_eff = rd_data[2*PB-1:PB];
      mid_eff = rd_data[PB-1:0];
    end else begin
      top_eff = '0;
      mid_eff = '0;
    end
  end

  // window: win_q[r*2] older, win_q[r*2+1] newer column of row r
  logic [PB-1:0] win_q [6];
  logic [PB-1:0] nb    [9];
  logic          has_strong;
  logic [7:0]    edge_val;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      nb[i] = win_q[i];
    end
    nb[6] = top_eff;
    nb[7] = mid_eff;
    nb[8] = pix1_q;
    has_strong = 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (32'(nb[i]) > 32'(high_thr_q)) begin
        has_strong = 1'b1;
      end
    end
    if (32'(win_q[3]) > 32'(high_thr_q)) begin
      edge_val = chys_pkg::EDGE_ON;
    end else if ((32'(win_q[3]) > 32'(low_thr_q)) && has_strong) begin
      edge_val = chys_pkg::EDGE_ON;
    end else begin
      edge_val = chys_pkg::EDGE_OFF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (s1_write) begin
      win_q[0] <= win_q[1];
      win_q[1] <= top_eff;
      win_q[2] <= win_q[3];
      win_q[3] <= mid_eff;
      win_q[4] <= win_q[5];
      win_q[5] <= pix1_q;
    end
  end

  // output register
  logic [7:0] edge_q;
  logic       start_q;
  logic       last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_write) begin
      edge_q  <= edge_val;
      start_q <= first1_q;
      last_q  <= last1_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign edge_value_o  = edge_q;
  assign frame_start_o = start_q;
  assign frame_last_o  = last_q;

  `CHYS_ASSERT(a_fill_bound, (32'(fill_q) <= LINE_DEPTH), "fill mark beyond line depth")
  `CHYS_ASSERT(a_fwd_taken, (in_acc && fwd_hit) |=> fwd_q, "same-column write not forwarded")
  `CHYS_ASSERT(a_out_from_s1, $rose(out_valid_q) |-> $past(s1_valid_q), "result without a word")
  `CHYS_ASSERT_ALWAYS(a_stall_busy, in_stall_o |-> s1_valid_q, "stall with empty stage")

endmodule

`default_nettype wire
